@@ design/cbm_pkg.sv @@
package cbm_pkg;

	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 96;
	localparam int OUT_PAD_W  = 6;

	localparam logic [9:0] PRESCALE_PERIOD = 10'd341;
	localparam logic [9:0] PRESCALE_STEP   = 10'd3;
	localparam logic [4:0] PRG_SECOND_LAST = 5'h1E;

	typedef enum logic [1:0] {
		CFG_MODE = 2'd0,
		CFG_VRC2 = 2'd1
	} cbm_cfg_idx_t;

	localparam logic [3:0] WIRE_RAW = 4'd0;
	localparam logic [3:0] WIRE_A   = 4'd1;
	localparam logic [3:0] WIRE_B   = 4'd2;
	localparam logic [3:0] WIRE_C   = 4'd3;
	localparam logic [3:0] WIRE_D   = 4'd4;
	localparam logic [3:0] WIRE_E   = 4'd5;
	localparam logic [3:0] WIRE_F   = 4'd6;
	localparam logic [3:0] WIRE_21  = 4'd7;
	localparam logic [3:0] WIRE_23  = 4'd8;
	localparam logic [3:0] WIRE_25  = 4'd9;

	localparam logic [3:0] BANK_PRG0 = 4'd8;
	localparam logic [3:0] BANK_MIRR = 4'd9;
	localparam logic [3:0] BANK_PRG1 = 4'd10;
	localparam logic [3:0] BANK_CHR0 = 4'd11;
	localparam logic [3:0] BANK_CHR1 = 4'd12;
	localparam logic [3:0] BANK_CHR2 = 4'd13;
	localparam logic [3:0] BANK_CHR3 = 4'd14;
	localparam logic [3:0] BANK_IRQ  = 4'd15;

	typedef enum logic [1:0] {
		IRQ_LATCH_LO = 2'd0,
		IRQ_LATCH_HI = 2'd1,
		IRQ_CTRL     = 2'd2,
		IRQ_ACK      = 2'd3
	} cbm_irq_reg_t;

	localparam logic [1:0] MIRR_REG_MODE = 2'd0;
	localparam logic [1:0] MIRR_REG_SWAP = 2'd2;

	localparam int CTRL_EN_ACK = 0;
	localparam int CTRL_EN     = 1;
	localparam int CTRL_CYCLE  = 2;

	typedef struct packed {
		logic       tick;
		logic [3:0] bank;
		logic [1:0] regs;
		logic [7:0] value;
		logic       vrc2;
	} cbm_cmd_t;

	typedef struct packed {
		logic [1:0]  mirroring;
		logic [35:0] chr_high;
		logic [35:0] chr_low;
		logic [4:0]  prg_c000;
		logic [4:0]  prg_a000;
		logic [4:0]  prg_8000;
	} cbm_bank_out_t;

	function automatic logic [1:0] swap_lines(input logic [1:0] v);
		logic [1:0] r;
		case (v)
			2'd1:    r = 2'd2;
			2'd2:    r = 2'd1;
			default: r = v;
		endcase
		return r;
	endfunction

endpackage

@@ design/cbm_decode.sv @@
module cbm_decode import cbm_pkg::*; (
	input  logic        tick,
	input  logic [3:0]  bank,
	input  logic [11:0] addr,
	input  logic [7:0]  value,
	input  logic [3:0]  mode,
	input  logic        vrc2,
	output cbm_cmd_t    cmd
);

	logic [1:0] regs;

	always_comb begin
		case (mode)
			WIRE_A:  regs = addr[2:1];
			WIRE_B:  regs = swap_lines(addr[1:0]);
			WIRE_C:  regs = addr[7:6];
			WIRE_D:  regs = swap_lines(addr[3:2]);
			WIRE_E:  regs = addr[3:2];
			WIRE_F:  regs = addr[1:0];
			WIRE_21: regs = addr[2:1] | addr[7:6];
			WIRE_23: regs = addr[1:0] | addr[3:2];
			WIRE_25: regs = swap_lines(addr[1:0] | addr[3:2]);
			default: regs = addr[1:0];
		endcase
	end

	always_comb begin
		cmd.tick  = tick;
		cmd.bank  = bank;
		cmd.regs  = regs;
		cmd.value = value;
		cmd.vrc2  = vrc2;
	end

endmodule

@@ design/cbm_bank.sv @@
module cbm_bank import cbm_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step,
	input  cbm_cmd_t      cmd,
	output cbm_bank_out_t view
);

	logic [4:0] prg_q [2];
	logic [8:0] chr_q [8];
	logic       swap_q;
	logic [1:0] mirror_q;

	logic [4:0] prg_d [2];
	logic [8:0] chr_d [8];
	logic       swap_d;
	logic [1:0] mirror_d;

	logic [1:0] pair;
	logic [2:0] slot;
	logic [8:0] chr_cur;

	// banks B..E map to slot pairs 0..3
	assign pair    = cmd.bank[1:0] + 2'd1;
	assign slot    = {pair, cmd.regs[1]};
	assign chr_cur = chr_q[slot];

	always_comb begin
		prg_d    = prg_q;
		chr_d    = chr_q;
		swap_d   = swap_q;
		mirror_d = mirror_q;
		if (step && !cmd.tick) begin
			case (cmd.bank)
				BANK_PRG0: prg_d[0] = cmd.value[4:0];
				BANK_PRG1: prg_d[1] = cmd.value[4:0];
				BANK_MIRR: begin
					if (cmd.vrc2) begin
						mirror_d = {1'b0, cmd.value[0]};
					end else if (cmd.regs == MIRR_REG_MODE) begin
						mirror_d = cmd.value[1:0];
					end else if (cmd.regs == MIRR_REG_SWAP) begin
						swap_d = cmd.value[1];
					end
				end
				BANK_CHR0, BANK_CHR1, BANK_CHR2, BANK_CHR3: begin
					if (!cmd.regs[0]) begin
						chr_d[slot] = {chr_cur[8:4], cmd.value[3:0]};
					end else begin
						chr_d[slot] = {cmd.vrc2 ? chr_cur[8] : cmd.value[4],
							cmd.value[3:0], chr_cur[3:0]};
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prg_q[0] <= 5'd0;
			prg_q[1] <= 5'd1;
			for (int i = 0; i < 8; i++) chr_q[i] <= 9'(i);
			swap_q   <= 1'b0;
			mirror_q <= 2'd0;
		end else begin
			prg_q    <= prg_d;
			chr_q    <= chr_d;
			swap_q   <= swap_d;
			mirror_q <= mirror_d;
		end
	end

	always_comb begin
		view.prg_8000  = swap_d ? PRG_SECOND_LAST : prg_d[0];
		view.prg_a000  = prg_d[1];
		view.prg_c000  = swap_d ? prg_d[0] : PRG_SECOND_LAST;
		view.chr_low   = {chr_d[3], chr_d[2], chr_d[1], chr_d[0]};
		view.chr_high  = {chr_d[7], chr_d[6], chr_d[5], chr_d[4]};
		view.mirroring = mirror_d;
	end

endmodule

@@ design/cbm_irq.sv @@
module cbm_irq import cbm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     step,
	input  cbm_cmd_t cmd,
	output logic     irq_next
);

	logic [2:0] ctrl_q, ctrl_d;
	logic [7:0] count_q, count_d;
	logic [7:0] reload_q, reload_d;
	logic [9:0] prescale_q, prescale_d;
	logic       pending_q, pending_d;
	logic       fire;

	always_comb begin
		ctrl_d     = ctrl_q;
		count_d    = count_q;
		reload_d   = reload_q;
		prescale_d = prescale_q;
		pending_d  = pending_q;
		fire       = 1'b0;
		if (step && cmd.tick) begin
			if (ctrl_q[CTRL_EN]) begin
				if (ctrl_q[CTRL_CYCLE]) begin
					fire = 1'b1;
				end else if (prescale_q <= PRESCALE_STEP) begin
					prescale_d = prescale_q + (PRESCALE_PERIOD - PRESCALE_STEP);
					fire       = 1'b1;
				end else begin
					prescale_d = prescale_q - PRESCALE_STEP;
				end
			end
			if (fire) begin
				if (count_q == 8'hFF) begin
					count_d   = reload_q;
					pending_d = 1'b1;
				end else begin
					count_d = count_q + 8'd1;
				end
			end
		end else if (step && cmd.bank == BANK_IRQ && !cmd.vrc2) begin
			case (cmd.regs)
				IRQ_LATCH_LO: reload_d = {reload_q[7:4], cmd.value[3:0]};
				IRQ_LATCH_HI: reload_d = {cmd.value[3:0], reload_q[3:0]};
				IRQ_CTRL: begin
					ctrl_d = cmd.value[2:0];
					if (cmd.value[CTRL_EN]) begin
						count_d    = reload_q;
						prescale_d = PRESCALE_PERIOD;
					end
					pending_d = 1'b0;
				end
				IRQ_ACK: begin
					ctrl_d[CTRL_EN] = ctrl_q[CTRL_EN_ACK];
					pending_d       = 1'b0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q     <= 3'd0;
			count_q    <= 8'd0;
			reload_q   <= 8'd0;
			prescale_q <= 10'd0;
			pending_q  <= 1'b0;
		end else begin
			ctrl_q     <= ctrl_d;
			count_q    <= count_d;
			reload_q   <= reload_d;
			prescale_q <= prescale_d;
			pending_q  <= pending_d;
		end
	end

	assign irq_next = pending_d;

endmodule

@@ design/cartridge_bank_mapper_irq.sv @@
// A beat accepted at the input passes the input register, then the result register.
// Throughput: one beat per cycle; the input register and the result register
// decouple the sides, so input stalls only while both are held by output backpressure.
// Reset (arst_n low, asynchronous): pipeline empty, wiring raw, VRC2 off,
// PRG banks 0/1, CHR slot i = i, mirroring 0, IRQ idle and clear.
module cartridge_bank_mapper_irq import cbm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // bank[3:0], addr[15:4], value[23:16]
	input  logic                  s_axis_tuser,  // func
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// prg_bank_8000[4:0], prg_bank_a000[9:5], prg_bank_c000[14:10],
	// chr_banks_low[50:15], chr_banks_high[86:51], mirroring[88:87], irq_asserted[89]
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [1:0]            cfg_index,
	input  logic [3:0]            cfg_data
);

	logic                 s1_valid_q;
	logic                 tick_s1;
	logic [IN_DATA_W-1:0] data_s1;
	logic                 out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;
	logic [3:0]           mode_q;
	logic                 vrc2_q;

	logic          adv;
	logic          in_beat;
	cbm_cmd_t      cmd;
	cbm_bank_out_t view;
	logic          irq_next;

	assign adv           = s1_valid_q && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !s1_valid_q || adv;
	assign in_beat       = s_axis_tvalid && s_axis_tready;
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= WIRE_RAW;
			vrc2_q <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_MODE: mode_q <= cfg_data;
				CFG_VRC2: vrc2_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_beat) begin
				s1_valid_q <= 1'b1;
			end else if (adv) begin
				s1_valid_q <= 1'b0;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			tick_s1 <= s_axis_tuser;
			data_s1 <= s_axis_tdata;
		end
		if (adv) begin
			out_data_q <= {{OUT_PAD_W{1'b0}}, irq_next, view};
		end
	end

	cbm_decode u_decode (
		.tick  (tick_s1),
		.bank  (data_s1[3:0]),
		.addr  (data_s1[15:4]),
		.value (data_s1[23:16]),
		.mode  (mode_q),
		.vrc2  (vrc2_q),
		.cmd   (cmd)
	);

	cbm_bank u_bank (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv),
		.cmd    (cmd),
		.view   (view)
	);

	cbm_irq u_irq (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (adv),
		.cmd      (cmd),
		.irq_next (irq_next)
	);

endmodule

@@ design/cbm_checker.sv @@
module cbm_checker import cbm_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_axis_tready,
	input logic                  m_axis_tvalid,
	input logic                  m_axis_tready,
	input logic [OUT_DATA_W-1:0] m_axis_tdata
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result beat changed while stalled");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[OUT_DATA_W-1:OUT_DATA_W-OUT_PAD_W] == '0)
		else $error("result padding not zero");

	a_prg_fixed: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[4:0] == PRG_SECOND_LAST) ||
			(m_axis_tdata[14:10] == PRG_SECOND_LAST))
		else $error("neither 8000 nor C000 holds the fixed bank");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("input stalled without output backpressure");

endmodule

bind cartridge_bank_mapper_irq cbm_checker u_cbm_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
